// File: rtl/route_longest_prefix_match_defines.svh
// ----------------------------------------------------------------------------
// route_longest_prefix_match_defines
// Assertion helpers for the route table block.
// ----------------------------------------------------------------------------
`ifndef ROUTE_LONGEST_PREFIX_MATCH_DEFINES_SVH
`define ROUTE_LONGEST_PREFIX_MATCH_DEFINES_SVH

// Plain property, sampled on clk_i, off during reset.
`define RLPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define RLPM_ASSERT_IMP(lbl, ante, cons, msg) \
  `RLPM_ASSERT(lbl, (ante) |-> (cons), msg)

// Implication: when ante holds, cons must hold in the next cycle.
`define RLPM_ASSERT_NXT(lbl, ante, cons, msg) \
  `RLPM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/rlpm_pkg.sv
// ----------------------------------------------------------------------------
// rlpm_pkg
// Shared types and constants of the longest-prefix-match route table.
// ----------------------------------------------------------------------------
package rlpm_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned PortCountDef    = 16;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 4;
  localparam int unsigned INDEX_W = 4;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Entry write broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  mask;
    logic [PORT_W-1:0]  port;
    logic               valid;
  } wr_t;

  // Lookup token walking the cell chain, carrying the best match so far.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              exact;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] dest;
  } token_t;

endpackage

// File: rtl/route_longest_prefix_match.sv
// A write beat is stored at its accept edge and gives no result, and is accepted whenever
// no lookup is in flight. A lookup walks one cell per cycle while the output does not
// stall, then enters the output register. The cell chain carries one token, so no beat
// is accepted until that token leaves the chain tail. Output stalls hold it at the tail.
// Reset (async, active low) clears all entry valid bits, tokens and the output beat.
// ----------------------------------------------------------------------------
// route_longest_prefix_match
// Route table as a chain of entry cells: exact match first, else longest mask.
// ----------------------------------------------------------------------------
`include "route_longest_prefix_match_defines.svh"

module route_longest_prefix_match #(
  parameter int unsigned TABLE_ENTRIES = rlpm_pkg::TableEntriesDef,
  parameter int unsigned PORT_COUNT    = rlpm_pkg::PortCountDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] entry_index, [35:4] entry_address, [67:36] entry_mask,
  // [71:68] entry_port, [72] entry_valid, [104:73] lookup_address, rest zero
  input  logic [111:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] found, [4:1] out_port, [5] exact_hit, rest zero
  output logic [7:0]   m_axis_tdata
);

  // Input beat fields
  rlpm_pkg::op_e               op;
  logic [rlpm_pkg::INDEX_W-1:0] in_index;
  logic [rlpm_pkg::ADDR_W-1:0]  in_addr;
  logic [rlpm_pkg::ADDR_W-1:0]  in_mask;
  logic [rlpm_pkg::PORT_W-1:0]  in_port;
  logic                         in_valid;
  logic [rlpm_pkg::ADDR_W-1:0]  in_dest;

  assign op       = rlpm_pkg::op_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[3:0];
  assign in_addr  = s_axis_tdata[35:4];
  assign in_mask  = s_axis_tdata[67:36];
  assign in_port  = s_axis_tdata[71:68];
  assign in_valid = s_axis_tdata[72];
  assign in_dest  = s_axis_tdata[104:73];

  logic in_acc;
  logic busy_q;
  logic en;

  // Only one lookup is in flight; writes land only while the chain is empty.
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Write broadcast, port clamped to the last valid port number.
  rlpm_pkg::wr_t wr;
  always_comb begin
    wr.en    = in_acc && (op == rlpm_pkg::OP_WRITE);
    wr.index = in_index;
    wr.addr  = in_addr;
    wr.mask  = in_mask;
    wr.valid = in_valid;
    if (32'(in_port) >= PORT_COUNT) begin
      wr.port = rlpm_pkg::PORT_W'(PORT_COUNT - 1);
    end else begin
      wr.port = in_port;
    end
  end

  // Token chain: tok[0] is the injected lookup, tok[g+1] the output of cell g.
  rlpm_pkg::token_t         tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] chain_vld;

  assign tok[0] = '{
    valid: in_acc && (op == rlpm_pkg::OP_LOOKUP),
    hit:   1'b0,
    exact: 1'b0,
    mask:  '0,
    port:  '0,
    dest:  in_dest
  };

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rlpm_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
    assign chain_vld[g] = tok[g+1].valid;
  end

  rlpm_pkg::token_t tail;
  assign tail = tok[TABLE_ENTRIES];

  // Freeze the chain only when the tail beat cannot move into the output.
  assign en = !(tail.valid && m_axis_tvalid && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (tok[0].valid) begin
      busy_q <= 1'b1;
    end else if (tail.valid && en) begin
      busy_q <= 1'b0;
    end
  end

  // Output register
  logic       m_valid_q;
  logic [7:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (tail.valid && en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid && en) begin
      m_data_q <= {2'b00, tail.exact, tail.port, tail.hit};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Assertions
  `RLPM_ASSERT_IMP(a_idle_chain_empty, !busy_q, chain_vld == '0,
                   "token in chain while idle")
  `RLPM_ASSERT(a_one_token, $countones(chain_vld) <= 1,
               "more than one lookup in the chain")
  `RLPM_ASSERT_NXT(a_tail_delivered, tail.valid && en, m_axis_tvalid,
                   "tail token not moved into output")
  `RLPM_ASSERT_IMP(a_exact_found, m_axis_tvalid && m_axis_tdata[5], m_axis_tdata[0],
                   "exact hit without found")

endmodule

// File: rtl/rlpm_cell.sv
// ----------------------------------------------------------------------------
// rlpm_cell
// One route entry plus a token stage: updates the running best match.
// ----------------------------------------------------------------------------
module rlpm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rlpm_pkg::wr_t    wr_i,
  input  rlpm_pkg::token_t tok_i,
  output rlpm_pkg::token_t tok_o
);

  logic                        valid_q;
  logic [rlpm_pkg::ADDR_W-1:0] addr_q;
  logic [rlpm_pkg::ADDR_W-1:0] mask_q;
  logic [rlpm_pkg::PORT_W-1:0] port_q;
  logic                        wr_hit;
  logic                        match_exact;
  logic                        match_pfx;
  rlpm_pkg::token_t            tok_d;
  rlpm_pkg::token_t            tok_q;

  assign wr_hit = wr_i.en && (32'(wr_i.index) == IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_hit) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      addr_q <= wr_i.addr;
      mask_q <= wr_i.mask;
      port_q <= wr_i.port;
    end
  end

  assign match_exact = valid_q && (addr_q == tok_i.dest);
  assign match_pfx   = valid_q && ((tok_i.dest & mask_q) == (addr_q & mask_q));

  // An exact hit anywhere overrides any prefix result; once exact, freeze.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.exact) begin
      if (match_exact) begin
        tok_d.hit   = 1'b1;
        tok_d.exact = 1'b1;
        tok_d.port  = port_q;
      end else if (match_pfx && (!tok_i.hit || (mask_q > tok_i.mask))) begin
        tok_d.hit  = 1'b1;
        tok_d.mask = mask_q;
        tok_d.port = port_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: tb/tb_route_longest_prefix_match.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_route_longest_prefix_match
// Self-checking bench for the longest-prefix-match route table.
// A queue of write and lookup beats feeds a clocked driver. A local route
// table model predicts every lookup at its accept edge. A clocked monitor
// compares each result beat field by field against the oldest prediction.
// Both sides idle at random. One long receiver hold-off fills the block so
// that it backs up into its input.
// ----------------------------------------------------------------------------
module tb_route_longest_prefix_match;

  localparam int unsigned NumEntries = rlpm_pkg::TableEntriesDef;
  localparam int unsigned PortCount  = rlpm_pkg::PortCountDef;
  localparam int unsigned ADDR_W     = rlpm_pkg::ADDR_W;
  localparam int unsigned PORT_W     = rlpm_pkg::PORT_W;
  localparam int unsigned INDEX_W    = rlpm_pkg::INDEX_W;
  localparam int          RandItems  = 1500;
  localparam int          HoldCycles = 400;
  localparam int          TailCycles = 3 * (rlpm_pkg::TableEntriesDef + 1);
  localparam longint      LimitNs    = 3_000_000;

  // One input beat as the generator builds it, plus the idle gap after it.
  typedef struct {
    rlpm_pkg::op_e      op;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  mask;
    logic [PORT_W-1:0]  port;
    logic               valid;
    logic [ADDR_W-1:0]  dest;
    int                 gap;
  } route_beat_t;

  // One lookup result.
  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] port;
    logic              exact;
  } route_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [3:0] entry_index, [35:4] entry_address, [67:36] entry_mask,
  // [71:68] entry_port, [72] entry_valid, [104:73] lookup_address, rest zero
  logic [111:0] s_axis_tdata  = '0;
  // [0] operation
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [0] found, [4:1] out_port, [5] exact_hit, rest zero
  logic [7:0]   m_axis_tdata;

  route_longest_prefix_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Route table model: updated and queried in accept order
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] rt_addr  [NumEntries];
  logic [ADDR_W-1:0] rt_mask  [NumEntries];
  logic [PORT_W-1:0] rt_port  [NumEntries];
  logic              rt_valid [NumEntries] = '{default: 1'b0};

  route_beat_t   route_beat_q [$];    // beats waiting for the driver
  route_result_t route_result_q [$];  // predicted lookup results, oldest first

  int total_beats = 0;
  int sent_cnt    = 0;
  int recv_cnt    = 0;
  int err_cnt     = 0;
  int n_write     = 0;
  int n_lookup    = 0;
  int n_exact     = 0;
  int n_prefix    = 0;
  int n_miss      = 0;

  // Exact address match first (lowest index), else the largest mask that
  // matches, lower index on a tie.
  function automatic route_result_t route_lookup_predict(logic [ADDR_W-1:0] dest);
    route_result_t     res;
    logic [ADDR_W-1:0] best;
    res  = '0;
    best = '0;
    for (int i = 0; i < NumEntries; i++) begin
      if (rt_valid[i] && rt_addr[i] == dest && !res.exact) begin
        res.found = 1'b1;
        res.exact = 1'b1;
        res.port  = rt_port[i];
      end
    end
    if (!res.exact) begin
      for (int i = 0; i < NumEntries; i++) begin
        if (rt_valid[i] && (dest & rt_mask[i]) == (rt_addr[i] & rt_mask[i]) &&
            (!res.found || rt_mask[i] > best)) begin
          res.found = 1'b1;
          best      = rt_mask[i];
          res.port  = rt_port[i];
        end
      end
    end
    return res;
  endfunction

  function automatic void route_apply(route_beat_t b);
    route_result_t res;
    if (b.op == rlpm_pkg::OP_WRITE) begin
      n_write++;
      if (b.index < NumEntries) begin
        rt_addr[b.index]  = b.addr;
        rt_mask[b.index]  = b.mask;
        rt_port[b.index]  = (b.port >= PortCount) ? PORT_W'(PortCount - 1) : b.port;
        rt_valid[b.index] = b.valid;
      end
    end else begin
      n_lookup++;
      res = route_lookup_predict(b.dest);
      if (res.exact)      n_exact++;
      else if (res.found) n_prefix++;
      else                n_miss++;
      route_result_q.push_back(res);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pops beats, honors each beat's idle gap, keeps tvalid steady
  // across back-to-back beats
  // --------------------------------------------------------------------------
  route_beat_t tx_cur;
  route_beat_t tx_nxt;
  int          tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        route_apply(tx_cur);
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (route_beat_q.size() > 0) begin
          tx_nxt        = route_beat_q.pop_front();
          tx_cur        <= tx_nxt;
          s_axis_tdata  <= {7'b0, tx_nxt.dest, tx_nxt.valid, tx_nxt.port,
                            tx_nxt.mask, tx_nxt.addr, tx_nxt.index};
          s_axis_tuser  <= tx_nxt.op;
          s_axis_tvalid <= 1'b1;
          tx_gap        <= tx_nxt.gap;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random receiver stalls, calm stretches, optional long hold-off
  // --------------------------------------------------------------------------
  logic          hold_rx     = 1'b0;
  int            rx_wait     = 0;
  int            rx_w;
  int            rx_calm     = 0;
  route_result_t rx_got;
  route_result_t rx_exp;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        recv_cnt <= recv_cnt + 1;
        rx_got.found = m_axis_tdata[0];
        rx_got.port  = m_axis_tdata[4:1];
        rx_got.exact = m_axis_tdata[5];
        if (route_result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result beat: found=%0b port=%0d exact=%0b",
                     $realtime, rx_got.found, rx_got.port, rx_got.exact);
        end else begin
          rx_exp = route_result_q.pop_front();
          if (rx_got !== rx_exp) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: result %0d found/port/exact: exp %0b/%0d/%0b, got %0b/%0d/%0b",
                       $realtime, recv_cnt, rx_exp.found, rx_exp.port, rx_exp.exact,
                       rx_got.found, rx_got.port, rx_got.exact);
          end
        end
        // next stall: calm stretch, or a random receiver wait
        if (rx_calm > 0) begin
          rx_calm--;
          rx_w = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          rx_calm = $urandom_range(20, 60);
          rx_w    = 0;
        end else begin
          rx_w = $urandom_range(0, 17);
        end
      end else begin
        rx_w = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait       <= rx_w;
      m_axis_tready <= !hold_rx && (rx_w == 0);
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    while (sent_cnt < 300) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  bit                tx_calm = 1'b0;
  // generator's own view of the table, used to aim lookups at real entries
  logic [ADDR_W-1:0] gen_addr  [NumEntries];
  logic [ADDR_W-1:0] gen_mask  [NumEntries];
  logic              gen_valid [NumEntries] = '{default: 1'b0};

  function automatic int pick_tx_gap();
    if (tx_calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    if (len == 0) return '0;
    return ~((ADDR_W'(1) << (ADDR_W - len)) - 1);
  endfunction

  // A few address neighborhoods so that random prefixes overlap.
  function automatic logic [ADDR_W-1:0] pool_addr();
    logic [7:0] top;
    case ($urandom_range(0, 3))
      0:       top = 8'h0a;
      1:       top = 8'hc0;
      2:       top = 8'hac;
      default: top = 8'h00;
    endcase
    return {top, 24'($urandom)};
  endfunction

  task automatic push_write(logic [INDEX_W-1:0] idx, logic [ADDR_W-1:0] a,
                            logic [ADDR_W-1:0] m, logic [PORT_W-1:0] p, logic v);
    route_beat_t b;
    b.op    = rlpm_pkg::OP_WRITE;
    b.index = idx;
    b.addr  = a;
    b.mask  = m;
    b.port  = p;
    b.valid = v;
    b.dest  = $urandom;  // unused by a write
    b.gap   = pick_tx_gap();
    gen_addr[idx]  = a;
    gen_mask[idx]  = m;
    gen_valid[idx] = v;
    route_beat_q.push_back(b);
  endtask

  task automatic push_lookup(logic [ADDR_W-1:0] d);
    route_beat_t b;
    b.op    = rlpm_pkg::OP_LOOKUP;
    b.index = INDEX_W'($urandom);  // entry fields unused by a lookup
    b.addr  = $urandom;
    b.mask  = $urandom;
    b.port  = PORT_W'($urandom);
    b.valid = 1'($urandom);
    b.dest  = d;
    b.gap   = pick_tx_gap();
    route_beat_q.push_back(b);
  endtask

  initial begin : main
    int                r;
    int                k;
    bit                have;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] m;

    // Directed: empty table, longer prefix, exact match, default route,
    // tie on equal masks, duplicate exact addresses, exact over longer mask,
    // a mask with holes, removal of entries.
    push_lookup(32'h0000_0000);
    push_lookup(32'hffff_ffff);
    push_write(4'd0, 32'h0a00_0000, 32'hff00_0000, 4'd3, 1'b1);
    push_lookup(32'h0a12_3456);
    push_write(4'd15, 32'h0a01_0000, 32'hffff_0000, 4'd15, 1'b1);
    push_lookup(32'h0a01_ffff);
    push_lookup(32'h0a00_0000);
    push_write(4'd5, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b1);
    push_lookup(32'hc0a8_0001);
    push_lookup(32'h0000_0000);
    push_write(4'd3, 32'h0a01_0000, 32'hffff_0000, 4'd7, 1'b1);
    push_lookup(32'h0a01_abcd);
    push_write(4'd7, 32'hffff_ffff, 32'hffff_ffff, 4'd9, 1'b1);
    push_write(4'd8, 32'hffff_ffff, 32'h0000_0000, 4'd12, 1'b1);
    push_lookup(32'hffff_ffff);
    push_write(4'd9, 32'h0a01_0203, 32'h0000_0000, 4'd11, 1'b1);
    push_lookup(32'h0a01_0203);
    push_write(4'd10, 32'h1234_5678, 32'h0f0f_0f0f, 4'd5, 1'b1);
    push_lookup(32'h0204_0608);
    push_write(4'd7, 32'hffff_ffff, 32'hffff_ffff, 4'd9, 1'b0);
    push_lookup(32'hffff_ffff);
    push_write(4'd8, 32'hffff_ffff, 32'h0000_0000, 4'd12, 1'b0);
    push_lookup(32'hffff_ffff);
    push_write(4'd5, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0);
    push_lookup(32'hffff_ffff);

    // Random: mostly prefix-shaped routes and lookups aimed at them.
    for (int n = 0; n < RandItems; n++) begin
      if (n % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 35) begin
        r = $urandom_range(0, 9);
        m = (r == 0) ? ADDR_W'($urandom) : prefix_mask($urandom_range(0, 32));
        a = (r == 1) ? ADDR_W'($urandom) : pool_addr();
        push_write(INDEX_W'($urandom_range(0, 15)), a, m, PORT_W'($urandom_range(0, 15)),
                   $urandom_range(0, 6) != 0);
      end else begin
        r    = $urandom_range(0, 99);
        k    = $urandom_range(0, 15);
        have = 1'b0;
        for (int j = 0; j < NumEntries && !have; j++) begin
          if (gen_valid[(k + j) % NumEntries]) begin
            k    = (k + j) % NumEntries;
            have = 1'b1;
          end
        end
        if (have && r < 25)
          push_lookup(gen_addr[k]);
        else if (have && r < 70)
          push_lookup((gen_addr[k] & gen_mask[k]) | (ADDR_W'($urandom) & ~gen_mask[k]));
        else if (r < 85)
          push_lookup(pool_addr());
        else
          push_lookup($urandom);
      end
    end
    total_beats = route_beat_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total_beats) @(posedge clk_i);
    while (route_result_q.size() != 0) @(posedge clk_i);
    // trailing window: any extra result beat is flagged by the monitor
    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d writes and %0d lookups (%0d exact, %0d prefix, %0d miss).",
             n_write, n_lookup, n_exact, n_prefix, n_miss);
    $display("Results checked: %0d, with a %0d-cycle receiver hold-off; mismatches: %0d.",
             recv_cnt, HoldCycles, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("Timeout: %0d of %0d beats sent, %0d results received.",
             sent_cnt, total_beats, recv_cnt);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
